@@ rtl/msws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_pkg
// Shared constants for the maximum square window sum block.
// ----------------------------------------------------------------------------
package msws_pkg;

  // Frame height limits and row counter
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;   // row index 0..MAX_HEIGHT-1
  localparam int H_W        = 13;   // height value 1..MAX_HEIGHT
  localparam int STEP_W     = 4;    // steps of the remainder unit, one per row bit
  localparam int CMP_W      = 14;   // common width for counter and bound compares

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int W_CFG_W    = 11;
  localparam int H_CFG_W    = 13;
  localparam int K_CFG_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  // Reset values of the registers before clamping
  localparam int W_RST = 1024;
  localparam int H_RST = 1024;
  localparam int K_RST = 2;

endpackage

@@ rtl/max_square_window_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_square_window_sum
// Streams a frame of signed samples and returns the largest KxK window sum.
// ----------------------------------------------------------------------------
// Result: out_valid_o is set once the frame's last sample has gone through
//   the column sum, row sum and max stages and the result register.
// Throughput: one sample per cycle; column sums are written back from the
//   column sum stage with forwarding; input stalls while a result is held,
//   while a configuration beat is offered and while busy after a write.
// Reset: asynchronous, clears counters and sums; no memory clearing pass.
module max_square_window_sum
  import msws_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16,
  localparam int WIN_BITS   = $clog2(MAX_WINDOW),
  localparam int SUM_BITS   = SAMPLE_BITS + 2 * WIN_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SUM_BITS-1:0]    best_sum_o,
  output logic                          found_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int KW       = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int COL_BITS = SAMPLE_BITS + WIN_BITS;
  localparam int RING_AW  = SLOT_W + COL_W;
  localparam int RING_DEPTH = 2 ** RING_AW;
  localparam int W_RST_EFF  = (MAX_WIDTH < W_RST) ? MAX_WIDTH : W_RST;
  localparam int K_RST_EFF  = (MAX_WINDOW < K_RST) ? MAX_WINDOW : K_RST;
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  typedef struct packed {
    logic act;       // this row and the rows above it make at least K rows
    logic col_zero;  // first column of the row
    logic col_ge_k;  // drop the column sum K places back
    logic win;       // a full window ends here
    logic last;      // last sample of the frame
  } flags_t;

  // --------------------------------------------------------------------------
  // Configuration and control
  // --------------------------------------------------------------------------
  logic [WW-1:0]     w_q;
  logic [H_W-1:0]    h_q;
  logic [KW-1:0]     k_q;
  logic              cfg_we;
  logic [WW-1:0]     w_eff;
  logic [H_W-1:0]    h_eff;
  logic [KW-1:0]     k_eff;
  logic [W_CFG_W-1:0] raw_w;
  logic [H_CFG_W-1:0] raw_h;
  logic [K_CFG_W-1:0] raw_k;

  logic              adv;
  logic              accept;
  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [SLOT_W-1:0] rem_r_q, rem_c_q;
  logic [SLOT_W-1:0] rem_r_nxt, rem_c_nxt;
  logic [SLOT_W:0]   t_r, t_c;
  logic [ROW_W-1:0]  col_ext;

  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] si_q;
  logic [WW-1:0]     fill_q;

  logic              out_valid_q;
  logic signed [SUM_BITS-1:0] best_q;
  logic              found_q;

  assign raw_w = cfg_data_i[W_CFG_W-1:0];
  assign raw_h = cfg_data_i[H_CFG_W-1:0];
  assign raw_k = cfg_data_i[K_CFG_W-1:0];

  always_comb begin
    if (raw_w == '0) begin
      w_eff = WW'(1);
    end else if (int'(raw_w) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(raw_w);
    end
    if (raw_h == '0) begin
      h_eff = H_W'(1);
    end else if (int'(raw_h) > MAX_HEIGHT) begin
      h_eff = H_W'(MAX_HEIGHT);
    end else begin
      h_eff = H_W'(raw_h);
    end
    if (raw_k == '0) begin
      k_eff = KW'(1);
    end else if (int'(raw_k) > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(raw_k);
    end
  end

  assign cfg_ready_o = !busy_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign adv         = !(out_valid_q && out_stall_i);
  // hold samples while a register beat is offered
  assign in_stall_o  = busy_q || cfg_valid_i || !adv;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WW'(W_RST_EFF);
      h_q <= H_W'(H_RST);
      k_q <= KW'(K_RST_EFF);
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  w_q <= w_eff;
        CFG_FRAME_HEIGHT: h_q <= h_eff;
        CFG_WINDOW_SIZE:  k_q <= k_eff;
        default: ;
      endcase
    end
  end

  // Restoring remainder of row and column by K, one bit a cycle
  assign col_ext = ROW_W'(col_q);
  assign t_r     = {rem_r_q, row_q[step_q]};
  assign t_c     = {rem_c_q, col_ext[step_q]};
  assign rem_r_nxt = (CMP_W'(t_r) >= CMP_W'(k_q)) ?
                     SLOT_W'(CMP_W'(t_r) - CMP_W'(k_q)) : SLOT_W'(t_r);
  assign rem_c_nxt = (CMP_W'(t_c) >= CMP_W'(k_q)) ?
                     SLOT_W'(CMP_W'(t_c) - CMP_W'(k_q)) : SLOT_W'(t_c);

  // --------------------------------------------------------------------------
  // Accept stage: counters, flags, memory addresses
  // --------------------------------------------------------------------------
  logic [WW-1:0]  c1;
  logic [H_W-1:0] r1;
  logic           col_end;
  logic           frame_end;
  logic           zero_col;
  flags_t         s0_flags;

  assign c1        = WW'(col_q) + WW'(1);
  assign r1        = H_W'(row_q) + H_W'(1);
  assign col_end   = c1 >= w_q;
  assign frame_end = (r1 >= h_q) && col_end;
  assign zero_col  = CMP_W'(col_q) >= CMP_W'(fill_q);

  always_comb begin
    s0_flags.act      = CMP_W'(r1) >= CMP_W'(k_q);
    s0_flags.col_zero = (col_q == '0);
    s0_flags.col_ge_k = CMP_W'(col_q) >= CMP_W'(k_q);
    s0_flags.win      = s0_flags.act && (CMP_W'(c1) >= CMP_W'(k_q));
    s0_flags.last     = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
      si_q    <= '0;
      fill_q  <= '0;
      busy_q  <= 1'b0;
      step_q  <= '0;
      rem_r_q <= '0;
      rem_c_q <= '0;
    end else if (cfg_we) begin
      busy_q  <= 1'b1;
      step_q  <= STEP_W'(ROW_W - 1);
      rem_r_q <= '0;
      rem_c_q <= '0;
    end else if (busy_q) begin
      rem_r_q <= rem_r_nxt;
      rem_c_q <= rem_c_nxt;
      if (step_q == '0) begin
        busy_q <= 1'b0;
        slot_q <= rem_r_nxt;
        si_q   <= rem_c_nxt;
      end else begin
        step_q <= step_q - STEP_W'(1);
      end
    end else if (accept) begin
      if (frame_end) begin
        row_q  <= '0;
        col_q  <= '0;
        slot_q <= '0;
        si_q   <= '0;
        fill_q <= '0;
      end else begin
        if (c1 > fill_q) begin
          fill_q <= c1;
        end
        if (col_end) begin
          col_q <= '0;
          si_q  <= '0;
          row_q <= row_q + ROW_W'(1);
          if (CMP_W'(slot_q) + CMP_W'(1) >= CMP_W'(k_q)) begin
            slot_q <= '0;
          end else begin
            slot_q <= slot_q + SLOT_W'(1);
          end
        end else begin
          col_q <= col_q + COL_W'(1);
          if (CMP_W'(si_q) + CMP_W'(1) >= CMP_W'(k_q)) begin
            si_q <= '0;
          end else begin
            si_q <= si_q + SLOT_W'(1);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [COL_BITS-1:0]    cs_rdata;
  logic                   s1_valid_q;
  logic [COL_W-1:0]       s1_c_q;
  logic signed [COL_BITS-1:0] s1_vs;

  msws_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_row_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i ({slot_q, col_q}),
    .wdata_i (sample_i),
    .re_i    (adv),
    .raddr_i ({slot_q, col_q}),
    .rdata_o (ring_rdata)
  );

  msws_ram #(
    .WIDTH (COL_BITS),
    .DEPTH (2 ** COL_W)
  ) u_col_sums (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && adv),
    .waddr_i (s1_c_q),
    .wdata_i (s1_vs),
    .re_i    (adv),
    .raddr_i (col_q),
    .rdata_o (cs_rdata)
  );

  // --------------------------------------------------------------------------
  // Column sum stage
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [SLOT_W-1:0]  s1_si_q;
  logic               s1_sub_q, s1_zero_q, s1_fwd_q;
  flags_t             s1_flags_q;
  logic signed [COL_BITS-1:0] s1_old, s1_ring;

  logic               s2_valid_q;
  logic signed [COL_BITS-1:0] s2_vs_q;
  logic [SLOT_W-1:0]  s2_si_q;
  flags_t             s2_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sample_q <= sample_i;
      s1_c_q      <= col_q;
      s1_si_q     <= si_q;
      s1_sub_q    <= CMP_W'(row_q) >= CMP_W'(k_q);
      s1_zero_q   <= zero_col;
      // previous beat writes the same column as this read
      s1_fwd_q    <= s1_valid_q && (s1_c_q == col_q);
      s1_flags_q  <= s0_flags;
      s2_vs_q     <= s1_vs;
      s2_si_q     <= s1_si_q;
      s2_flags_q  <= s1_flags_q;
    end
  end

  always_comb begin
    if (s1_zero_q) begin
      s1_old = '0;
    end else if (s1_fwd_q) begin
      s1_old = s2_vs_q;
    end else begin
      s1_old = $signed(cs_rdata);
    end
    s1_ring = s1_sub_q ? COL_BITS'($signed(ring_rdata)) : '0;
  end

  assign s1_vs = s1_old + COL_BITS'(s1_sample_q) - s1_ring;

  // --------------------------------------------------------------------------
  // Horizontal sum stage
  // --------------------------------------------------------------------------
  logic signed [COL_BITS-1:0] shift_q [MAX_WINDOW];
  logic signed [SUM_BITS-1:0] hs_q, hs_base, hs_drop, hs_new;
  logic               s3_valid_q;
  logic signed [SUM_BITS-1:0] s3_hs_q;
  flags_t             s3_flags_q;

  assign hs_base = s2_flags_q.col_zero ? '0 : hs_q;
  assign hs_drop = s2_flags_q.col_ge_k ? SUM_BITS'(shift_q[s2_si_q]) : '0;
  assign hs_new  = hs_base + SUM_BITS'(s2_vs_q) - hs_drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        shift_q[i] <= '0;
      end
    end else if (adv && s2_valid_q) begin
      if (s2_flags_q.last) begin
        hs_q <= '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
          shift_q[i] <= '0;
        end
      end else if (s2_flags_q.act) begin
        hs_q             <= hs_new;
        shift_q[s2_si_q] <= s2_vs_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_hs_q    <= hs_new;
      s3_flags_q <= s2_flags_q;
    end
  end

  // --------------------------------------------------------------------------
  // Running maximum and result register
  // --------------------------------------------------------------------------
  logic signed [SUM_BITS-1:0] max_q, max_new;
  logic               any_q, any_new;

  always_comb begin
    max_new = max_q;
    if (s3_flags_q.win && (!any_q || (s3_hs_q > max_q))) begin
      max_new = s3_hs_q;
    end
    any_new = any_q || s3_flags_q.win;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= SUM_MIN;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q && s3_flags_q.last;
      if (s3_valid_q) begin
        if (s3_flags_q.last) begin
          max_q <= SUM_MIN;
          any_q <= 1'b0;
        end else begin
          max_q <= max_new;
          any_q <= any_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q && s3_flags_q.last) begin
      best_q  <= any_new ? max_new : '0;
      found_q <= any_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_sum_o  = best_q;
  assign found_o     = found_q;

`ifndef SYNTHESIS
  // ring slot and window phase stay below K whenever samples may enter
  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ((CMP_W'(slot_q) < CMP_W'(k_q)) && (CMP_W'(si_q) < CMP_W'(k_q))))
    else $error("ring slot or window phase out of range");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s3_valid_q && s3_flags_q.last))
    else $error("result without a last beat");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (best_sum_o == '0))
    else $error("no window but nonzero sum");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result held");
`endif

endmodule

@@ rtl/msws_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msws_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module msws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // old contents on a same-address write
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams frames of signed samples through max_square_window_sum under
// several frame and window settings, predicts the largest window sum of each
// frame and compares every result beat with the prediction or with a typed result.
// ----------------------------------------------------------------------------
module tb;
  import msws_pkg::*;

  localparam int MAX_W   = 1024;
  localparam int MAX_K   = 32;
  localparam int SUM_W   = 26;
  localparam int LIMIT   = 60000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int { PAT_CONST, PAT_RAND, PAT_EDGE } sample_pat_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] best;
    logic                    found;
  } window_result_t;

  typedef struct {
    int          width;
    int          height;
    int          win;
    sample_pat_e pat;
    int          value;
    bit          typed;
    int          exp_best;
    bit          exp_found;
  } frame_case_t;

  logic                    clk_i;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic signed [15:0]      sample_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [SUM_W-1:0] best_sum_o;
  logic                    found_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i  = '0;

  max_square_window_sum uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .best_sum_o  (best_sum_o),
    .found_o     (found_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state
  logic [W_CFG_W-1:0] cfg_width;
  logic [H_CFG_W-1:0] cfg_height;
  logic [K_CFG_W-1:0] cfg_win;
  int row_ring [MAX_K*MAX_W];
  int col_sums [MAX_W];
  int col_shift [MAX_K];
  int run_sum;
  int best_so_far;
  bit any_window;
  int row_idx;
  int col_idx;

  window_result_t pending_results [$];

  bit failed;
  int src_idle_pct;
  int sink_idle_pct;
  bit hold_req;
  int hold_left;
  int cycles;

  frame_case_t cases [18] = '{
    '{3,    3,    2,  PAT_CONST, 1,      1'b1, 4,         1'b1},
    '{1,    1,    1,  PAT_CONST, 32767,  1'b1, 32767,     1'b1},
    '{1,    1,    1,  PAT_CONST, -32768, 1'b1, -32768,    1'b1},
    '{2,    4,    3,  PAT_CONST, 5,      1'b1, 0,         1'b0},
    '{4,    2,    3,  PAT_CONST, 5,      1'b1, 0,         1'b0},
    '{0,    0,    0,  PAT_CONST, 9,      1'b1, 9,         1'b1},
    '{3,    2,    1,  PAT_RAND,  0,      1'b0, 0,         1'b0},
    '{5,    5,    2,  PAT_RAND,  0,      1'b0, 0,         1'b0},
    '{4,    4,    4,  PAT_EDGE,  0,      1'b0, 0,         1'b0},
    '{4,    4,    4,  PAT_CONST, 32767,  1'b1, 524272,    1'b1},
    '{4,    4,    4,  PAT_CONST, -32768, 1'b1, -524288,   1'b1},
    '{3,    2,    63, PAT_CONST, 7,      1'b1, 0,         1'b0},
    '{20,   2,    2,  PAT_RAND,  0,      1'b0, 0,         1'b0},
    '{1,    5,    1,  PAT_CONST, -1,     1'b1, -1,        1'b1},
    '{1,    20,   32, PAT_RAND,  0,      1'b1, 0,         1'b0},
    '{7,    6,    3,  PAT_EDGE,  0,      1'b0, 0,         1'b0},
    '{2,    2,    2,  PAT_CONST, 0,      1'b1, 0,         1'b1},
    '{3,    3,    1,  PAT_RAND,  0,      1'b0, 0,         1'b0}
  };

  function automatic int clamp_reg(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_frame();
    col_sums    = '{default: 0};
    col_shift   = '{default: 0};
    run_sum     = 0;
    best_so_far = -(1 << (SUM_W - 1));
    any_window  = 1'b0;
    row_idx     = 0;
    col_idx     = 0;
  endfunction

  // Advance the window sums by one sample; returns 1 on the frame's last sample.
  function automatic bit window_sum_step(input logic signed [15:0] s,
                                         output window_result_t res);
    int w, h, k, r, c, slot, si, col_new, win_new;
    logic signed [20:0] col_wrap;
    logic signed [SUM_W-1:0] win_wrap;
    w = clamp_reg(int'(cfg_width), MAX_W);
    h = clamp_reg(int'(cfg_height), MAX_HEIGHT);
    k = clamp_reg(int'(cfg_win), MAX_K);
    r = row_idx;
    c = col_idx % MAX_W;
    slot = r % k;
    res = '0;

    col_new = col_sums[c] + int'(s);
    if (r >= k) col_new -= row_ring[slot*MAX_W + c];
    col_wrap = col_new[20:0];
    col_new = col_wrap;
    row_ring[slot*MAX_W + c] = int'(s);
    col_sums[c] = col_new;

    if (r + 1 >= k) begin
      si = c % k;
      win_new = (c == 0) ? 0 : run_sum;
      win_new += col_new;
      if (c >= k) win_new -= col_shift[si];
      win_wrap = win_new[SUM_W-1:0];
      win_new = win_wrap;
      col_shift[si] = col_new;
      run_sum = win_new;
      if (c + 1 >= k) begin
        if (!any_window || win_new > best_so_far) best_so_far = win_new;
        any_window = 1'b1;
      end
    end

    if ((r + 1 >= h) && (c + 1 >= w)) begin
      res.best  = any_window ? best_so_far[SUM_W-1:0] : '0;
      res.found = any_window;
      clear_frame();
      return 1'b1;
    end
    if (c + 1 >= w) begin
      col_idx = 0;
      row_idx = r + 1;
    end else begin
      col_idx = c + 1;
    end
    return 1'b0;
  endfunction

  // Result side: check each beat, then pick the stall for the next cycle.
  always @(posedge clk_i) begin : result_sink
    window_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("best_sum: no result pending, got %0d (found %0b)", best_sum_o, found_o);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (best_sum_o !== want.best) begin
          $error("best_sum: expected %0d, got %0d", want.best, best_sum_o);
          failed = 1'b1;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found_o);
          failed = 1'b1;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_width  = data[W_CFG_W-1:0];
      CFG_FRAME_HEIGHT: cfg_height = data[H_CFG_W-1:0];
      CFG_WINDOW_SIZE:  cfg_win    = data[K_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_frame(input int w, input int h, input int k);
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
    cfg_write(CFG_WINDOW_SIZE, k);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [15:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic signed [15:0] pick_sample(sample_pat_e pat, int value);
    logic [31:0] r;
    r = $urandom;
    case (pat)
      PAT_CONST: return value[15:0];
      PAT_EDGE: begin
        case (r[17:16])
          2'd0:    return 16'sh7FFF;
          2'd1:    return 16'sh8000;
          default: return r[15:0];
        endcase
      end
      default: return r[15:0];
    endcase
  endfunction

  // Send one whole frame; the typed result, where given, replaces the prediction.
  task automatic send_frame(input sample_pat_e pat, input int value, input bit typed,
                            input window_result_t typed_res, output int n);
    window_result_t got;
    logic signed [15:0] s;
    n = clamp_reg(int'(cfg_width), MAX_W) * clamp_reg(int'(cfg_height), MAX_HEIGHT);
    for (int i = 0; i < n; i++) begin
      s = pick_sample(pat, value);
      send_sample(s);
      if (window_sum_step(s, got)) pending_results.push_back(typed ? typed_res : got);
    end
  endtask

  // Drain the result side before touching the registers again.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    window_result_t typed_res;
    sample_pat_e pat;
    int n, rand_samples, rand_frames, w, h, k, nf;
    bit pressed;

    failed = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    src_idle_pct = 33;
    sink_idle_pct = 62;
    row_ring = '{default: 0};
    clear_frame();
    cfg_width  = W_CFG_W'(W_RST);
    cfg_height = H_CFG_W'(H_RST);
    cfg_win    = K_CFG_W'(K_RST);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An index that maps to no register must change nothing.
    cfg_write(CFG_UNUSED, 'h1FFF);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);

    foreach (cases[i]) begin
      program_frame(cases[i].width, cases[i].height, cases[i].win);
      typed_res.best  = cases[i].exp_best[SUM_W-1:0];
      typed_res.found = cases[i].exp_found;
      send_frame(cases[i].pat, cases[i].value, cases[i].typed, typed_res, n);
      settle();
    end

    typed_res = '0;
    rand_samples = 0;
    rand_frames = 0;
    pressed = 1'b0;
    while (rand_samples < 420 || rand_frames < 40) begin
      if (rand_samples < 140) begin
        src_idle_pct = 33;
        sink_idle_pct = 62;
      end else if (rand_samples < 280) begin
        src_idle_pct = 62;
        sink_idle_pct = 33;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end

      if (rand_samples >= 280 && !pressed) begin
        // Hold the result side while short frames keep arriving.
        pressed = 1'b1;
        program_frame(2, 1, 1);
        hold_req = 1'b1;
        repeat (40) begin
          send_frame(PAT_RAND, 0, 1'b0, typed_res, n);
          rand_samples += n;
          rand_frames++;
        end
        settle();
      end else begin
        if ($urandom_range(9) == 0) begin
          w = $urandom_range(8, 48);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(0, 7);
          h = $urandom_range(0, 7);
        end
        k = $urandom_range(0, 5);
        program_frame(w, h, k);
        nf = $urandom_range(1, 3);
        repeat (nf) begin
          case ($urandom_range(9))
            0:       pat = PAT_CONST;
            1, 2, 3: pat = PAT_EDGE;
            default: pat = PAT_RAND;
          endcase
          send_frame(pat, int'(pick_sample(PAT_EDGE, 0)), 1'b0, typed_res, n);
          rand_samples += n;
          rand_frames++;
        end
        settle();
      end
    end

    settle();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ max_square_window_sum.f @@
rtl/msws_pkg.sv
rtl/msws_ram.sv
rtl/max_square_window_sum.sv
verif/tb.sv
